@@ design/smcd_pkg.sv @@
// Shared types and constants for the serial motor command decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package smcd_pkg;

    localparam int VALUE_W     = 32;
    localparam int CODE_W      = 3;
    localparam int QUEUE_DEPTH = 4;

    // ASCII codes used by the parser
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_V       = 8'h56;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_O       = 8'h4F;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_T       = 8'h54;

    // Result command codes
    localparam logic [CODE_W-1:0] CMD_SPEED     = 3'd0;
    localparam logic [CODE_W-1:0] CMD_MOVE      = 3'd1;
    localparam logic [CODE_W-1:0] CMD_POSITION  = 3'd2;
    localparam logic [CODE_W-1:0] CMD_ZERO      = 3'd3;
    localparam logic [CODE_W-1:0] CMD_TIMER     = 3'd4;
    localparam logic [CODE_W-1:0] CMD_INCORRECT = 3'd5;

    typedef enum logic [1:0] {
        K_CMD,
        K_ARG,
        K_END
    } t_kind;

    // One classified byte handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] chr;       // case-folded for command bytes
        logic       is_digit;
        logic       is_minus;
    } t_beat;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        logic               valid;
    } t_result;

endpackage

`default_nettype wire

@@ design/serial_motor_command_decoder.sv @@
// Serial motor command decoder: in front end, beat queue, back end.
// Top level of the block; depends on smcd_pkg, smcd_front, smcd_fifo, smcd_back.
//
// Usage:
//   Input channel i_rx_valid / o_rx_stall carries one received ASCII byte per
//   beat. Bytes up to the first space form the command word (case-folded),
//   later bytes the signed decimal argument. A newline, or a space inside the
//   argument, closes the line and yields one result beat on
//   o_res_valid / i_res_stall: command code, argument value and argument
//   valid flag. All other bytes yield no result.
//   Throughput is one byte per cycle while the queue is not full. The closing
//   byte is written into the queue when it is accepted, and its result is
//   loaded into the output register when the back end takes it from the queue.
//   While the receiver stalls, the result register holds and the back end
//   keeps consuming non-closing beats; only a further closing beat waits.
//   The four-entry queue fills after that and then stalls the input.
//   Reset (synchronous, active low) empties the queue, drops any result and
//   returns the parser to the start of a line; no clearing pass is needed.
`default_nettype none

module serial_motor_command_decoder
    import smcd_pkg::*;
#(
    parameter int COMMAND_CHARS = 4,
    parameter int ARGUMENT_BITS = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_rx_valid,
    output logic               o_rx_stall,
    input  wire  [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  wire                i_res_stall,
    output logic [CODE_W-1:0]  o_command_code,
    output logic [VALUE_W-1:0] o_argument_value,
    output logic               o_argument_valid
);

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_beat   beat_in;
    t_beat   beat_out;
    t_result res;

    smcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .i_full     (full),
        .o_rx_stall (o_rx_stall),
        .o_push     (push),
        .o_beat     (beat_in)
    );

    smcd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (beat_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_beat  (beat_out)
    );

    smcd_back #(
        .COMMAND_CHARS (COMMAND_CHARS),
        .ARGUMENT_BITS (ARGUMENT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_beat      (beat_out),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (res)
    );

    assign o_command_code   = res.code;
    assign o_argument_value = res.value;
    assign o_argument_valid = res.valid;

endmodule

`default_nettype wire

@@ design/smcd_front.sv @@
// Front end: accepts received bytes, tracks command/argument part, classifies.
// Depends on smcd_pkg.
`default_nettype none

module smcd_front
    import smcd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_rx_valid,
    input  wire [7:0]  i_rx_byte,
    input  wire        i_full,
    output logic       o_rx_stall,
    output logic       o_push,
    output t_beat      o_beat
);

    logic r_in_arg;
    logic n_in_arg;
    logic accept;
    logic is_lf;
    logic is_space;

    assign o_rx_stall = i_full;
    assign accept     = i_rx_valid && !i_full;
    assign is_lf      = (i_rx_byte == CH_LF);
    assign is_space   = (i_rx_byte == CH_SPACE);

    always_comb begin
        n_in_arg        = r_in_arg;
        o_push          = 1'b0;
        o_beat.kind     = K_CMD;
        o_beat.chr      = i_rx_byte;
        o_beat.is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
        o_beat.is_minus = (i_rx_byte == CH_MINUS);
        if (accept) begin
            if (is_lf || (r_in_arg && is_space)) begin
                o_push      = 1'b1;
                o_beat.kind = K_END;
                n_in_arg    = 1'b0;
            end else if (r_in_arg) begin
                o_push      = 1'b1;
                o_beat.kind = K_ARG;
            end else if (is_space) begin
                // first space only switches part, back end needs no beat
                n_in_arg = 1'b1;
            end else begin
                o_push = 1'b1;
                if ((i_rx_byte >= CH_LOW_A) && (i_rx_byte <= CH_LOW_Z)) begin
                    o_beat.chr = i_rx_byte - CASE_SHIFT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_arg <= 1'b0;
        end else begin
            r_in_arg <= n_in_arg;
        end
    end

endmodule

`default_nettype wire

@@ design/smcd_fifo.sv @@
// Short beat queue between front and back ends.
// Depends on smcd_pkg for the beat type.
`default_nettype none

module smcd_fifo
    import smcd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_push,
    input  t_beat  i_beat,
    input  wire    i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_beat  o_beat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_beat            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_beat  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/smcd_back.sv @@
// Back end: accumulates command word and argument, matches the line on its
// end beat and holds the result in an output register. Depends on smcd_pkg.
`default_nettype none

module smcd_back
    import smcd_pkg::*;
#(
    parameter int COMMAND_CHARS = 4,
    parameter int ARGUMENT_BITS = 32
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_empty,
    input  t_beat  i_beat,
    output logic   o_pop,
    output logic   o_res_valid,
    input  wire    i_res_stall,
    output t_result o_res
);

    localparam int IDX_W = $clog2(COMMAND_CHARS);
    localparam int LEN_W = $clog2(COMMAND_CHARS + 2);
    localparam int MAG_W = ARGUMENT_BITS - 1;
    localparam int EXT_W = ARGUMENT_BITS + 3;

    logic [7:0]       r_chars [COMMAND_CHARS];
    logic [LEN_W-1:0] r_len;
    logic [MAG_W-1:0] r_mag;
    logic             r_neg;
    logic [1:0]       r_cnt;
    logic             r_bad;
    logic             r_res_valid;
    t_result          r_res;

    logic             out_free;
    logic [EXT_W-1:0] mag_next;
    logic             overflow;
    logic             arg_ok;
    logic [VALUE_W-1:0] mag_ext;
    t_result          n_res;

    assign out_free    = !r_res_valid || !i_res_stall;
    assign o_pop       = !i_empty && ((i_beat.kind != K_END) || out_free);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // magnitude * 10 + digit as two shifts and adds
    assign mag_next = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                    + EXT_W'(i_beat.chr[3:0]);
    assign overflow = |mag_next[EXT_W-1:MAG_W];
    assign mag_ext  = VALUE_W'(r_mag);

    always_comb begin
        logic is_v1;
        logic is_g1;
        logic is_pos1;
        logic is_set1;
        logic is_s;
        is_v1   = (r_len == LEN_W'(2)) && (r_chars[0] == CH_V) && (r_chars[1] == CH_ONE);
        is_g1   = (r_len == LEN_W'(2)) && (r_chars[0] == CH_G) && (r_chars[1] == CH_ONE);
        is_pos1 = (r_len == LEN_W'(4)) && (r_chars[0] == CH_P) && (r_chars[1] == CH_O)
                  && (r_chars[2] == CH_S) && (r_chars[3] == CH_ONE);
        is_set1 = (r_len == LEN_W'(4)) && (r_chars[0] == CH_S) && (r_chars[1] == CH_E)
                  && (r_chars[2] == CH_T) && (r_chars[3] == CH_ONE);
        is_s    = (r_len == LEN_W'(1)) && (r_chars[0] == CH_S);

        // empty argument is fine; a lone minus is not
        arg_ok = (r_cnt == 2'd0) || (!r_bad && !(r_neg && (r_cnt == 2'd1)));

        n_res.valid = arg_ok;
        if (!arg_ok) begin
            n_res.value = '0;
        end else if (r_neg) begin
            n_res.value = '0 - mag_ext;
        end else begin
            n_res.value = mag_ext;
        end

        priority if (is_v1 && arg_ok) begin
            n_res.code = CMD_SPEED;
        end else if (is_g1 && arg_ok) begin
            n_res.code = CMD_MOVE;
        end else if (is_pos1) begin
            n_res.code = CMD_POSITION;
        end else if (is_set1) begin
            n_res.code = CMD_ZERO;
        end else if (is_s) begin
            n_res.code = CMD_TIMER;
        end else begin
            n_res.code = CMD_INCORRECT;
        end
    end

    // command characters carry no reset; entries past the length are never read
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_beat.kind == K_CMD) && (r_len < LEN_W'(COMMAND_CHARS))) begin
            r_chars[r_len[IDX_W-1:0]] <= i_beat.chr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_beat.kind == K_END)) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_cnt       <= '0;
            r_bad       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_pop && (i_beat.kind == K_END)) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (i_beat.kind)
                    K_CMD: begin
                        if (r_len < LEN_W'(COMMAND_CHARS + 1)) begin
                            r_len <= r_len + 1'b1;
                        end
                    end
                    K_ARG: begin
                        if ((r_cnt == 2'd0) && i_beat.is_minus) begin
                            r_neg <= 1'b1;
                        end else if (i_beat.is_digit) begin
                            if (!r_bad) begin
                                if (overflow) begin
                                    r_bad <= 1'b1;
                                end else begin
                                    r_mag <= mag_next[MAG_W-1:0];
                                end
                            end
                        end else begin
                            r_bad <= 1'b1;
                        end
                        if (r_cnt != 2'd2) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    K_END: begin
                        r_len       <= '0;
                        r_mag       <= '0;
                        r_neg       <= 1'b0;
                        r_cnt       <= '0;
                        r_bad       <= 1'b0;
                    end
                    default: begin
                        r_bad <= r_bad;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ design/smcd_checker.sv @@
// Port-level checks for the serial motor command decoder, bound to the top.
// Depends on smcd_pkg and serial_motor_command_decoder.
`default_nettype none

module smcd_checker
    import smcd_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_res_valid,
    input wire               i_res_stall,
    input wire [CODE_W-1:0]  o_command_code,
    input wire [VALUE_W-1:0] o_argument_value,
    input wire               o_argument_valid
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_command_code)
            && $stable(o_argument_value) && $stable(o_argument_valid))
        else $error("stalled result beat changed");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_command_code <= CMD_INCORRECT))
        else $error("command code out of range");

    a_bad_arg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_argument_valid |-> (o_argument_value == '0))
        else $error("bad argument with nonzero value");

    a_motion_needs_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && ((o_command_code == CMD_SPEED) || (o_command_code == CMD_MOVE))
            |-> o_argument_valid)
        else $error("speed or move command with bad argument");

endmodule

bind serial_motor_command_decoder smcd_checker u_smcd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_res_valid      (o_res_valid),
    .i_res_stall      (i_res_stall),
    .o_command_code   (o_command_code),
    .o_argument_value (o_argument_value),
    .o_argument_valid (o_argument_valid)
);

`default_nettype wire
